>>> hw/rtl/tsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package tsb_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_BORDER_MODE   = 3'd2;
	localparam logic [2:0] REG_FILTER_MODE   = 3'd3;
	localparam logic [2:0] REG_EXPOSURE_GAIN = 3'd4;

	// Item kinds carried in tuser
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF    = 256;
	localparam int MAX_HEIGHT_DEF   = 256;
	localparam int CHANNEL_BITS_DEF = 16;

	// Fixed field widths
	localparam int SIZE_BITS   = 9;
	localparam int CHAN_W      = 16;
	localparam int TEXEL_BITS  = 3 * CHAN_W;
	localparam int QUEUE_DEPTH = 4;

	// Register reset values
	localparam logic [8:0]  RST_IMAGE_SIZE = 9'd256;
	localparam logic [15:0] RST_GAIN       = 16'd256;

	// Settings seen by the front end, sizes already limited to the store
	typedef struct packed {
		logic [SIZE_BITS-1:0] width;
		logic [SIZE_BITS-1:0] height;
		logic                 repeat_mode;
		logic                 bilinear;
	} tsb_cfg_t;

	// Classified item as it travels through the queue
	typedef struct packed {
		logic        is_wr;
		logic        wr_ok;
		logic [15:0] fx;
		logic [15:0] fy;
	} tsb_ctrl_t;

endpackage

>>> hw/rtl/texture_sampler_bilinear.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler_bilinear
// Texture unit with an RGB texel store, nearest or bilinear filtering, clamp
// or repeat addressing and an exposure gain on the result.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ stream. tuser selects the kind: a write item loads
// one texel and gives no result, a sample item returns one colour on the m_
// stream. Results leave in the order their samples came in.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata while the
// block is idle; it takes effect at once.
// A sample passes two front stages, the queue, the store read and four
// arithmetic stages. Throughput is one item per cycle while the receiver
// does not stall: the store is kept in two copies, each with two read
// ports, so all four neighbours are read in the same cycle.
// A stalled receiver holds the back pipeline; the four-entry queue keeps the
// front accepting until it fills, then s_tready drops.
// Reset clears all control state and sets the registers to 256 x 256,
// repeat addressing, bilinear filtering and unit gain. The texel store is
// not cleared: a texel must be written before it is sampled.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear
	import tsb_pkg::*;
#(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// texel_col, texel_row, write_red, write_green, write_blue, coord_u, coord_v
	input  logic [111:0] s_tdata,
	// action
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// sample_red, sample_green, sample_blue
	output logic [47:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW    = $bits(tsb_ctrl_t) + TEXEL_BITS + 4 * AW;

	function automatic logic [8:0] eff_size(logic [8:0] r, int mx);
		if (r == 9'd0) begin
			return 9'd1;
		end else if (int'(r) > mx) begin
			return 9'(mx);
		end else begin
			return r;
		end
	endfunction

	logic [8:0]  width_q, height_q;
	logic        border_q, filter_q;
	logic [15:0] gain_q;
	tsb_cfg_t    cfg;

	logic               f_push, f_full, f_pop, f_empty;
	tsb_ctrl_t          f_ctrl, b_ctrl;
	logic [3:0][AW-1:0] f_addr, b_addr;
	logic [47:0]        f_texel, b_texel;
	logic [QW-1:0]      f_data, b_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_SIZE;
			height_q <= RST_IMAGE_SIZE;
			border_q <= 1'b1;
			filter_q <= 1'b1;
			gain_q   <= RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:   width_q  <= cfg_wdata[8:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_wdata[8:0];
				REG_BORDER_MODE:   border_q <= cfg_wdata[0];
				REG_FILTER_MODE:   filter_q <= cfg_wdata[0];
				REG_EXPOSURE_GAIN: gain_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.width       = eff_size(width_q, MAX_WIDTH);
	assign cfg.height      = eff_size(height_q, MAX_HEIGHT);
	assign cfg.repeat_mode = border_q;
	assign cfg.bilinear    = filter_q;

	tsb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_col    (s_tdata[7:0]),
		.in_row    (s_tdata[15:8]),
		.in_texel  (s_tdata[63:16]),
		.in_u      (s_tdata[87:64]),
		.in_v      (s_tdata[111:88]),
		.q_push    (f_push),
		.q_full    (f_full),
		.q_ctrl    (f_ctrl),
		.q_addr    (f_addr),
		.q_texel   (f_texel)
	);

	assign f_data                    = {f_addr, f_texel, f_ctrl};
	assign {b_addr, b_texel, b_ctrl} = b_data;

	tsb_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (f_data),
		.full      (f_full),
		.pop       (f_pop),
		.pop_data  (b_data),
		.empty     (f_empty)
	);

	tsb_back #(
		.DEPTH        (DEPTH),
		.AW           (AW),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain_q),
		.q_empty   (f_empty),
		.q_pop     (f_pop),
		.q_ctrl    (b_ctrl),
		.q_addr    (b_addr),
		.q_texel   (b_texel),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> hw/rtl/tsb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_fifo
// Short queue between the address front end and the filter back end.
// ----------------------------------------------------------------------------
module tsb_fifo
	import tsb_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Storage slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill level never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill level above depth");

	// A lone push raises the fill level by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill level wrong after push");

	// A lone pop lowers the fill level by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue fill level wrong after pop");

	// Pointers sit together whenever the queue is empty.
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with empty flag");

endmodule

>>> hw/rtl/tsb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_front
// Accepts items, scales coordinates and works out the four texel addresses
// and blend fractions under clamp or repeat addressing.
// ----------------------------------------------------------------------------
module tsb_front
	import tsb_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int AW         = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsb_cfg_t             cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_action,
	input  logic [7:0]           in_col,
	input  logic [7:0]           in_row,
	input  logic [47:0]          in_texel,
	input  logic signed [23:0]   in_u,
	input  logic signed [23:0]   in_v,
	output logic                 q_push,
	input  logic                 q_full,
	output tsb_ctrl_t            q_ctrl,
	output logic [3:0][AW-1:0]   q_addr,
	output logic [47:0]          q_texel
);

	typedef struct packed {
		logic [8:0]  i0;
		logic [8:0]  i1;
		logic [15:0] frac;
	} axis_t;

	// Clamp a signed texel index into 0 .. size-1
	function automatic logic [8:0] clamp_idx(logic signed [19:0] x, logic [8:0] s);
		logic signed [19:0] top;
		top = $signed({11'b0, s}) - 20'sd1;
		if (x < 20'sd0) begin
			return 9'd0;
		end else if (x > top) begin
			return top[8:0];
		end else begin
			return x[8:0];
		end
	endfunction

	// Index pair and fraction along one axis. In repeat mode the integer part
	// of the coordinate adds whole multiples of the size, so only the
	// fractional part times the size is needed to find the wrapped index.
	function automatic axis_t axis(logic signed [33:0] p, logic [24:0] fs,
			logic [8:0] s, logic rep, logic bil);
		logic signed [34:0] q;
		logic signed [19:0] i0;
		logic signed [19:0] i1;
		logic signed [25:0] tq;
		logic signed [9:0]  t;
		logic [9:0]         t1;
		axis_t              r;
		q  = {p[33], p} - (bil ? 35'sd32768 : 35'sd0);
		i0 = {q[34], q[34:16]};
		i1 = i0 + 20'sd1;
		tq = $signed({1'b0, fs}) - (bil ? 26'sd32768 : 26'sd0);
		t  = tq[25:16];
		t1 = t + 10'sd1;
		if (rep) begin
			r.i0 = t[9] ? (s - 9'd1) : t[8:0];
			r.i1 = (t1 == {1'b0, s}) ? 9'd0 : t1[8:0];
		end else begin
			r.i0 = clamp_idx(i0, s);
			r.i1 = clamp_idx(i1, s);
		end
		// Nearest filtering touches only the one texel, so every read points there.
		if (!bil) begin
			r.i1 = r.i0;
		end
		r.frac = bil ? q[15:0] : 16'd0;
		return r;
	endfunction

	// Store address of a texel, rows of MAX_WIDTH entries
	function automatic logic [AW-1:0] taddr(logic [8:0] y, logic [8:0] x);
		logic [31:0] full_addr;
		full_addr = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
		return full_addr[AW-1:0];
	endfunction

	logic               adv;
	logic               v_s1, v_s2;
	logic               wr_s1, wr_s2;
	logic [7:0]         col_s1, col_s2;
	logic [7:0]         row_s1, row_s2;
	logic [47:0]        texel_s1, texel_s2;
	logic signed [24:0] cu_s1, cv_s1;
	logic signed [33:0] pu_s2, pv_s2;
	logic [24:0]        fu_s2, fv_s2;
	axis_t              ax_x, ax_y;

	assign adv      = !v_s2 || !q_full;
	assign in_ready = adv;
	assign q_push   = v_s2 && !q_full;

	// Valid flags of the two front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage one takes the item and forms 1 - v; stage two scales by the size
	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s1    <= (in_action == ACT_WRITE);
			col_s1   <= in_col;
			row_s1   <= in_row;
			texel_s1 <= in_texel;
			cu_s1    <= {in_u[23], in_u};
			cv_s1    <= 25'sd65536 - {in_v[23], in_v};
			wr_s2    <= wr_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			texel_s2 <= texel_s1;
			pu_s2    <= cu_s1 * $signed({1'b0, cfg.width});
			pv_s2    <= cv_s1 * $signed({1'b0, cfg.height});
			fu_s2    <= cu_s1[15:0] * cfg.width;
			fv_s2    <= cv_s1[15:0] * cfg.height;
		end
	end

	assign ax_x = axis(pu_s2, fu_s2, cfg.width, cfg.repeat_mode, cfg.bilinear);
	assign ax_y = axis(pv_s2, fv_s2, cfg.height, cfg.repeat_mode, cfg.bilinear);

	// Queue entry: a write uses the first address, a sample all four
	always_comb begin
		q_ctrl.is_wr = wr_s2;
		q_ctrl.wr_ok = (32'(col_s2) < 32'(MAX_WIDTH)) && (32'(row_s2) < 32'(MAX_HEIGHT));
		q_ctrl.fx    = ax_x.frac;
		q_ctrl.fy    = ax_y.frac;
		q_texel      = texel_s2;
		if (wr_s2) begin
			q_addr[0] = taddr({1'b0, row_s2}, {1'b0, col_s2});
		end else begin
			q_addr[0] = taddr(ax_y.i0, ax_x.i0);
		end
		q_addr[1] = taddr(ax_y.i0, ax_x.i1);
		q_addr[2] = taddr(ax_y.i1, ax_x.i0);
		q_addr[3] = taddr(ax_y.i1, ax_x.i1);
	end

endmodule

>>> hw/rtl/tsb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_back
// Texel store and filter pipeline: writes texels, reads four texels a cycle
// if not stalled; blends, applies the exposure gain, rounds and saturates.
// ----------------------------------------------------------------------------
module tsb_back
	import tsb_pkg::*;
#(
	parameter int DEPTH        = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
	parameter int AW           = 16,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        gain,
	input  logic               q_empty,
	output logic               q_pop,
	input  tsb_ctrl_t          q_ctrl,
	input  logic [3:0][AW-1:0] q_addr,
	input  logic [47:0]        q_texel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [47:0]        out_data
);

	localparam logic [32:0] LIMIT = (33'd1 << CHANNEL_BITS) - 33'd1;

	// Two copies of the store, one per texel row, each read at two addresses
	logic [47:0] mem_a_q [DEPTH];
	logic [47:0] mem_b_q [DEPTH];

	logic              be;
	logic              wr_en;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [47:0]       tex_s1 [4];
	logic [15:0]       fx_s1, fy_s1, fy_s2;
	logic [32:0]       pa_s2 [3];
	logic [32:0]       pb_s2 [3];
	logic [32:0]       pc_s2 [3];
	logic [32:0]       pd_s2 [3];
	logic [49:0]       m0_s3 [3];
	logic [49:0]       m1_s3 [3];
	logic [63:0]       prod_s4 [3];
	logic [47:0]       out_s5;
	logic [16:0]       wx0, wy0;

	assign be        = !v_s5 || out_ready;
	assign q_pop     = be && !q_empty;
	assign wr_en     = q_pop && q_ctrl.is_wr && q_ctrl.wr_ok;
	assign out_valid = v_s5;
	assign out_data  = out_s5;
	assign wx0       = 17'h10000 - {1'b0, fx_s1};
	assign wy0       = 17'h10000 - {1'b0, fy_s2};

	// Texel writes go to both copies
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a_q[q_addr[0]] <= q_texel;
			mem_b_q[q_addr[0]] <= q_texel;
		end
	end

	// Registered reads of the four neighbours
	always_ff @(posedge clk) begin
		if (be) begin
			tex_s1[0] <= mem_a_q[q_addr[0]];
			tex_s1[1] <= mem_a_q[q_addr[1]];
			tex_s1[2] <= mem_b_q[q_addr[2]];
			tex_s1[3] <= mem_b_q[q_addr[3]];
			fx_s1     <= q_ctrl.fx;
			fy_s1     <= q_ctrl.fy;
		end
	end

	// Valid flags; only sample items travel past the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (be) begin
			v_s1 <= q_pop && !q_ctrl.is_wr;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Horizontal weights, vertical weights, gain, then rounding per channel
	always_ff @(posedge clk) begin
		logic [32:0] top, bot;
		logic [49:0] acc;
		logic [64:0] rnd;
		logic [24:0] r;
		if (be) begin
			fy_s2 <= fy_s1;
			for (int c = 0; c < 3; c++) begin
				pa_s2[c] <= tex_s1[0][c*CHAN_W +: CHAN_W] * wx0;
				pb_s2[c] <= tex_s1[1][c*CHAN_W +: CHAN_W] * {1'b0, fx_s1};
				pc_s2[c] <= tex_s1[2][c*CHAN_W +: CHAN_W] * wx0;
				pd_s2[c] <= tex_s1[3][c*CHAN_W +: CHAN_W] * {1'b0, fx_s1};
				top = pa_s2[c] + pb_s2[c];
				bot = pc_s2[c] + pd_s2[c];
				m0_s3[c] <= top * wy0;
				m1_s3[c] <= bot * {1'b0, fy_s2};
				acc = m0_s3[c] + m1_s3[c];
				prod_s4[c] <= acc[47:0] * gain;
				rnd = {1'b0, prod_s4[c]} + (65'd1 << 39);
				r   = rnd[64:40];
				if ({8'b0, r} > LIMIT) begin
					out_s5[c*CHAN_W +: CHAN_W] <= LIMIT[15:0];
				end else begin
					out_s5[c*CHAN_W +: CHAN_W] <= r[15:0];
				end
			end
		end
	end

	// A stalled result stays put and the pipeline does not pop.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !out_ready) |-> !q_pop)
		else $error("queue popped while output stalled");

	// A write item never produces a result in the next stage.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_ctrl.is_wr) |=> !v_s1)
		else $error("write item produced a result");

	// A sample item popped enters the read stage.
	a_sample_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_ctrl.is_wr) |=> v_s1)
		else $error("sample item lost at the store");

endmodule
